// File: rtl/core/phr_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// phr_pkg
// Shared types, constants and hue helpers for the pixel hue replace block.
// ----------------------------------------------------------------------------
package phr_pkg;

    localparam int PIX_W   = 8;
    localparam int HUE_W   = 9;
    localparam int WGT_W   = 6;
    // ramp coefficient: weight (0..60) scaled by 2^COEF_SHIFT / 60
    localparam int COEF_SHIFT = 20;
    localparam int COEF_W     = 21;

    localparam logic [HUE_W-1:0] HUE_FULL_TURN  = 9'd360;
    localparam logic [HUE_W-1:0] HUE_THIRD_TURN = 9'd120;
    localparam logic [HUE_W-1:0] HUE_SIXTH_TURN = 9'd60;
    localparam logic [HUE_W-1:0] HUE_HALF_TURN  = 9'd180;
    localparam logic [HUE_W-1:0] HUE_RAMP_DOWN  = 9'd240;

    // ceil(2^20 / 60); exact floor division for products below 2^20 / 44
    localparam logic [COEF_W-1:0] COEF_RECIP = 21'd17477;

    typedef logic [PIX_W-1:0]  t_pix;
    typedef logic [HUE_W-1:0]  t_hue;
    typedef logic [COEF_W-1:0] t_coef;

    typedef struct packed {
        t_coef red;
        t_coef green;
        t_coef blue;
    } t_coef_set;

    // fold a hue below 2 * 360 back into 0..359
    function automatic t_hue hue_wrap(input logic [HUE_W:0] h);
        logic [HUE_W:0] folded;
        begin
            folded = (h >= {1'b0, HUE_FULL_TURN}) ? h - {1'b0, HUE_FULL_TURN} : h;
            return folded[HUE_W-1:0];
        end
    endfunction

    // piecewise ramp weight in sixtieths of the span
    function automatic logic [WGT_W-1:0] hue_weight(input t_hue t);
        t_hue w;
        begin
            if (t < HUE_SIXTH_TURN) begin
                w = t;
            end else if (t < HUE_HALF_TURN) begin
                w = HUE_SIXTH_TURN;
            end else if (t < HUE_RAMP_DOWN) begin
                w = HUE_RAMP_DOWN - t;
            end else begin
                w = '0;
            end
            return w[WGT_W-1:0];
        end
    endfunction

    function automatic t_coef hue_coef(input t_hue t);
        t_coef w;
        begin
            w = {{(COEF_W-WGT_W){1'b0}}, hue_weight(t)};
            return w * COEF_RECIP;
        end
    endfunction

    // full coefficient set for a raw register value (0..511)
    function automatic t_coef_set coefs_for(input t_hue raw);
        t_hue      h;
        t_coef_set c;
        begin
            h       = hue_wrap({1'b0, raw});
            c.red   = hue_coef(hue_wrap({1'b0, h} + {1'b0, HUE_THIRD_TURN}));
            c.green = hue_coef(h);
            c.blue  = hue_coef(hue_wrap({1'b0, h} + {1'b0, HUE_RAMP_DOWN}));
            return c;
        end
    endfunction

endpackage

// File: rtl/core/phr_cfg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// phr_cfg
// Target hue register, held as per-channel ramp coefficients.
// ----------------------------------------------------------------------------
module phr_cfg (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_cfg_wr_en,
    input  phr_pkg::t_hue       i_cfg_wr_data,
    output phr_pkg::t_coef_set  o_coefs
);
    import phr_pkg::*;

    t_coef_set r_coefs;
    t_coef_set n_coefs;

    always_comb begin
        n_coefs = r_coefs;
        if (i_cfg_wr_en) begin
            n_coefs = coefs_for(i_cfg_wr_data);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_coefs <= coefs_for('0);
        end else begin
            r_coefs <= n_coefs;
        end
    end

    assign o_coefs = r_coefs;

endmodule

// File: rtl/core/phr_chan.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// phr_chan
// One output channel: min plus the span scaled by the ramp coefficient.
// ----------------------------------------------------------------------------
module phr_chan (
    input  phr_pkg::t_pix  i_mx,
    input  phr_pkg::t_pix  i_mn,
    input  phr_pkg::t_coef i_coef,
    output phr_pkg::t_pix  o_pix
);
    import phr_pkg::*;

    logic [PIX_W+COEF_W-1:0] w_prod;
    t_pix                    w_span;
    t_pix                    w_step;

    assign w_span = i_mx - i_mn;
    assign w_prod = {{COEF_W{1'b0}}, w_span} * {{PIX_W{1'b0}}, i_coef};
    // never exceeds the span, so the top bit of the shifted product is zero
    assign w_step = w_prod[COEF_SHIFT+PIX_W-1:COEF_SHIFT];
    assign o_pix  = i_mn + w_step;

endmodule

// File: rtl/core/pixel_hue_replace.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pixel_hue_replace
// Replaces the HSL hue of an RGB pixel, keeping saturation and lightness.
// ----------------------------------------------------------------------------
// Usage
//   Input channel: i_in_valid / o_in_stall with i_red_in, i_green_in,
//   i_blue_in. A transaction completes when valid is high and stall is low.
//   Output channel: o_out_valid / i_out_stall with the three result channels.
//   Every input transaction gives exactly one output transaction, in order.
//   Each pixel passes the input register, then the result register, which
//   drives the outputs. Throughput: one pixel per clock while the output
//   does not stall; the whole conversion is a max/min, a subtract, one
//   8x21 multiply and an add per channel.
//   A stall on the output holds the result register; the input register still
//   takes one more pixel, after which o_in_stall follows i_out_stall.
//   Configuration: i_cfg_wr_en writes i_cfg_wr_data as target hue in degrees
//   (values of 360 and up wrap). Write only while the pipe is empty.
//   Reset (synchronous, active low) empties both stages and sets hue to 0.
// ----------------------------------------------------------------------------
module pixel_hue_replace (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_cfg_wr_en,
    input  phr_pkg::t_hue  i_cfg_wr_data,
    input  logic           i_in_valid,
    output logic           o_in_stall,
    input  phr_pkg::t_pix  i_red_in,
    input  phr_pkg::t_pix  i_green_in,
    input  phr_pkg::t_pix  i_blue_in,
    output logic           o_out_valid,
    input  logic           i_out_stall,
    output phr_pkg::t_pix  o_red_out,
    output phr_pkg::t_pix  o_green_out,
    output phr_pkg::t_pix  o_blue_out
);
    import phr_pkg::*;

    // per-channel ramp coefficients from the hue register
    t_coef_set w_coefs;

    // input stage
    logic r_s1_vld;
    t_pix r_s1_red, r_s1_green, r_s1_blue;
    // result stage
    logic r_s2_vld;
    t_pix r_s2_red, r_s2_green, r_s2_blue;

    logic w_s2_adv;   // result register can load
    logic w_s1_adv;   // input register can load
    t_pix w_mx, w_mn;
    t_pix w_red, w_green, w_blue;

    phr_cfg u_cfg (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_wr_en   (i_cfg_wr_en),
        .i_cfg_wr_data (i_cfg_wr_data),
        .o_coefs       (w_coefs)
    );

    // pipeline flow control: a stage loads when it is empty or drains
    assign w_s2_adv   = !r_s2_vld || !i_out_stall;
    assign w_s1_adv   = !r_s1_vld || w_s2_adv;
    assign o_in_stall = !w_s1_adv;

    // largest and smallest channel of the registered pixel
    always_comb begin
        w_mx = r_s1_red;
        w_mn = r_s1_red;
        if (r_s1_green > w_mx) w_mx = r_s1_green;
        if (r_s1_blue  > w_mx) w_mx = r_s1_blue;
        if (r_s1_green < w_mn) w_mn = r_s1_green;
        if (r_s1_blue  < w_mn) w_mn = r_s1_blue;
    end

    // a gray pixel has zero span, so each channel comes out as min = input
    phr_chan u_chan_red (
        .i_mx (w_mx), .i_mn (w_mn), .i_coef (w_coefs.red),   .o_pix (w_red)
    );
    phr_chan u_chan_green (
        .i_mx (w_mx), .i_mn (w_mn), .i_coef (w_coefs.green), .o_pix (w_green)
    );
    phr_chan u_chan_blue (
        .i_mx (w_mx), .i_mn (w_mn), .i_coef (w_coefs.blue),  .o_pix (w_blue)
    );

    // control
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_vld <= 1'b0;
            r_s2_vld <= 1'b0;
        end else begin
            if (w_s1_adv) begin
                r_s1_vld <= i_in_valid;
            end
            if (w_s2_adv) begin
                r_s2_vld <= r_s1_vld;
            end
        end
    end

    // payload
    always_ff @(posedge i_clk) begin
        if (w_s1_adv && i_in_valid) begin
            r_s1_red   <= i_red_in;
            r_s1_green <= i_green_in;
            r_s1_blue  <= i_blue_in;
        end
        if (w_s2_adv && r_s1_vld) begin
            r_s2_red   <= w_red;
            r_s2_green <= w_green;
            r_s2_blue  <= w_blue;
        end
    end

    assign o_out_valid = r_s2_vld;
    assign o_red_out   = r_s2_red;
    assign o_green_out = r_s2_green;
    assign o_blue_out  = r_s2_blue;

`ifndef SYNTHESIS
    // both stages full and output stalled: no room for another pixel
    a_full_stalls: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_s1_vld && r_s2_vld && i_out_stall) |-> o_in_stall)
        else $error("input taken while pipe is full");

    // a pixel in the input stage moves to the output when the output frees
    a_s1_moves: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_s1_vld && w_s2_adv) |=> o_out_valid)
        else $error("pixel lost between stages");

    // gray pixels pass through unchanged
    a_gray_pass: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_s1_vld && w_s2_adv && r_s1_red == r_s1_green && r_s1_green == r_s1_blue)
        |=> (o_red_out == $past(r_s1_red) && o_green_out == $past(r_s1_green)
             && o_blue_out == $past(r_s1_blue)))
        else $error("gray pixel altered");

    // reset empties the result stage
    a_reset_empty: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_out_valid)
        else $error("output valid after reset");
`endif

endmodule

// File: tb/sv/hue_replace_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// hue_replace_checker
// Watches the pixel channels of the hue replace block, predicts each
// output pixel from the accepted input and the current hue, and compares.
// ----------------------------------------------------------------------------
module hue_replace_checker (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_cfg_wr_en,
    input  phr_pkg::t_hue  i_cfg_wr_data,
    input  logic           i_in_valid,
    input  logic           i_in_stall,
    input  phr_pkg::t_pix  i_red_in,
    input  phr_pkg::t_pix  i_green_in,
    input  phr_pkg::t_pix  i_blue_in,
    input  logic           i_out_valid,
    input  logic           i_out_stall,
    input  phr_pkg::t_pix  i_red_out,
    input  phr_pkg::t_pix  i_green_out,
    input  phr_pkg::t_pix  i_blue_out,
    output int             o_fail_count,
    output int             o_pending
);
    import phr_pkg::*;

    localparam int DEG_TURN  = 360;
    localparam int DEG_THIRD = 120;

    typedef struct packed {
        t_pix red;
        t_pix green;
        t_pix blue;
    } t_rgb;

    t_hue hue_copy = '0;
    t_rgb expected_pixels[$];
    t_rgb sent_px;
    t_rgb want_px;
    int   mismatch_count = 0;

    assign o_fail_count = mismatch_count;
    assign o_pending    = expected_pixels.size();

    // level of one channel for its offset hue, truncating division
    function automatic t_pix ramp_level(input int deg, input int hi, input int lo);
        int span;
        span = hi - lo;
        if (deg < 60) return t_pix'(lo + (span * deg) / 60);
        if (deg < 180) return t_pix'(hi);
        if (deg < 240) return t_pix'(lo + (span * (240 - deg)) / 60);
        return t_pix'(lo);
    endfunction

    function automatic t_rgb recolor_pixel(input t_rgb px, input t_hue hue);
        t_rgb res;
        int   hi;
        int   lo;
        int   base;
        hi = px.red;
        lo = px.red;
        if (px.green > hi) hi = px.green;
        if (px.blue > hi) hi = px.blue;
        if (px.green < lo) lo = px.green;
        if (px.blue < lo) lo = px.blue;
        if (hi == lo) return px;            // gray passes through
        base = int'(hue) % DEG_TURN;
        res.red   = ramp_level((base + DEG_THIRD) % DEG_TURN, hi, lo);
        res.green = ramp_level(base, hi, lo);
        res.blue  = ramp_level((base + 2 * DEG_THIRD) % DEG_TURN, hi, lo);
        return res;
    endfunction

    task automatic check_channel(input string name, input t_pix want, input t_pix got);
        if (want !== got) begin
            $display("%0t ns: %s mismatch, expected %0d, actual %0d",
                     $time, name, want, got);
            mismatch_count++;
        end
    endtask

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            hue_copy = '0;
            expected_pixels.delete();
        end else begin
            if (i_out_valid && !i_out_stall) begin
                if (expected_pixels.size() == 0) begin
                    $display("%0t ns: unexpected output %0d/%0d/%0d, nothing outstanding",
                             $time, i_red_out, i_green_out, i_blue_out);
                    mismatch_count++;
                end else begin
                    want_px = expected_pixels.pop_front();
                    check_channel("red_out", want_px.red, i_red_out);
                    check_channel("green_out", want_px.green, i_green_out);
                    check_channel("blue_out", want_px.blue, i_blue_out);
                end
            end
            if (i_in_valid && !i_in_stall) begin
                sent_px = '{red: i_red_in, green: i_green_in, blue: i_blue_in};
                expected_pixels.push_back(recolor_pixel(sent_px, hue_copy));
            end
            // register write takes effect for later transactions
            if (i_cfg_wr_en) begin
                hue_copy = i_cfg_wr_data;
            end
        end
    end

endmodule

// File: tb/sv/pixel_hue_replace_test.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pixel_hue_replace_test
// Drives pixels and target hue writes into the hue replace block with random
// gaps and output stalls; a checker beside the block predicts and compares.
// ----------------------------------------------------------------------------
module pixel_hue_replace_test;
    import phr_pkg::*;

    // all block inputs start known at time zero
    logic clk         = 1'b0;
    logic rst_n       = 1'b0;
    logic cfg_wr_en   = 1'b0;
    t_hue cfg_wr_data = '0;
    logic in_valid    = 1'b0;
    t_pix red_in      = '0;
    t_pix green_in    = '0;
    t_pix blue_in     = '0;
    logic out_stall   = 1'b0;

    logic in_stall;
    logic out_valid;
    t_pix red_out;
    t_pix green_out;
    t_pix blue_out;

    int fail_count;
    int pending;

    // calm phases: no gaps on either side, back-to-back transactions
    bit calm         = 1'b0;
    int pixels_sent  = 0;
    int hue_writes   = 0;

    // hue register corners: 0, just above, last valid degree, wrap point, all ones
    t_hue hue_corners [5] = '{9'd0, 9'd1, 9'd359, 9'd360, 9'd511};

    always begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    pixel_hue_replace dut (
        .i_clk         (clk),
        .i_rst_n       (rst_n),
        .i_cfg_wr_en   (cfg_wr_en),
        .i_cfg_wr_data (cfg_wr_data),
        .i_in_valid    (in_valid),
        .o_in_stall    (in_stall),
        .i_red_in      (red_in),
        .i_green_in    (green_in),
        .i_blue_in     (blue_in),
        .o_out_valid   (out_valid),
        .i_out_stall   (out_stall),
        .o_red_out     (red_out),
        .o_green_out   (green_out),
        .o_blue_out    (blue_out)
    );

    hue_replace_checker u_check (
        .i_clk         (clk),
        .i_rst_n       (rst_n),
        .i_cfg_wr_en   (cfg_wr_en),
        .i_cfg_wr_data (cfg_wr_data),
        .i_in_valid    (in_valid),
        .i_in_stall    (in_stall),
        .i_red_in      (red_in),
        .i_green_in    (green_in),
        .i_blue_in     (blue_in),
        .i_out_valid   (out_valid),
        .i_out_stall   (out_stall),
        .i_red_out     (red_out),
        .i_green_out   (green_out),
        .i_blue_out    (blue_out),
        .o_fail_count  (fail_count),
        .o_pending     (pending)
    );

    // One input transaction. Entered and left at a falling edge. Valid stays
    // high on exit so a zero gap to the next pixel keeps it high without a
    // drop; whoever comes next either loads new data or lowers valid.
    task automatic send_pixel(input t_pix r, input t_pix g, input t_pix b);
        int gap;
        gap = calm ? 0 : $urandom_range(0, 8);
        if (gap > 0) begin
            in_valid = 1'b0;
            repeat (gap) @(negedge clk);
        end
        in_valid = 1'b1;
        red_in   = r;
        green_in = g;
        blue_in  = b;
        // sampled at the rising edge, where the transaction completes
        @(posedge clk);
        while (in_stall) @(posedge clk);
        @(negedge clk);
        pixels_sent++;
    endtask

    // Hue writes only with the pipe empty: stop input, wait for every
    // outstanding result, then pulse the write enable for one cycle.
    task automatic set_hue(input t_hue value);
        in_valid = 1'b0;
        while (pending != 0) @(negedge clk);
        @(negedge clk);
        cfg_wr_en   = 1'b1;
        cfg_wr_data = value;
        @(negedge clk);
        cfg_wr_en = 1'b0;
        hue_writes++;
    endtask

    // two saturated pixels and one mixed pixel, reused under each directed hue
    task automatic send_corner_trio();
        send_pixel(8'd255, 8'd0, 8'd128);
        send_pixel(8'd0, 8'd255, 8'd1);
        send_pixel(8'd200, 8'd37, 8'd90);
    endtask

    // Receiver: before each output transaction hold stall for a random
    // number of cycles, then release until one result is taken.
    initial begin : sink
        int hold;
        forever begin
            hold = calm ? 0 : $urandom_range(0, 8);
            if (hold > 0) begin
                out_stall = 1'b1;
                repeat (hold) @(negedge clk);
            end
            out_stall = 1'b0;
            @(posedge clk);
            while (!out_valid) @(posedge clk);
            @(negedge clk);
        end
    end

    initial begin : stimulus
        int   phase;
        int   kind;
        t_hue hue;
        t_pix r;
        t_pix g;
        t_pix b;

        // synchronous reset held from time zero, released mid-cycle
        repeat (9) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        // --- directed part ---
        // reset hue of zero; gray pixels (black, white, mid gray) must pass
        // through, then primaries, a near-gray and a one-code span
        send_pixel(8'd0, 8'd0, 8'd0);
        send_pixel(8'd255, 8'd255, 8'd255);
        send_pixel(8'd77, 8'd77, 8'd77);
        send_pixel(8'd255, 8'd0, 8'd0);
        send_pixel(8'd0, 8'd255, 8'd0);
        send_pixel(8'd0, 8'd0, 8'd255);
        send_pixel(8'd255, 8'd254, 8'd255);
        send_pixel(8'd1, 8'd0, 8'd0);

        // 360 wraps to 0, 511 is past the turn, 359 the last degree; 240 and 60
        // put channel hues right on the ramp boundaries, 59 just below them
        set_hue(9'd360);
        send_corner_trio();
        set_hue(9'd511);
        send_corner_trio();
        set_hue(9'd359);
        send_corner_trio();
        set_hue(9'd240);
        send_corner_trio();
        set_hue(9'd60);
        send_corner_trio();
        set_hue(9'd59);
        send_corner_trio();

        // --- random part ---
        for (phase = 0; phase < 22; phase++) begin
            calm = (phase % 4 == 3);
            if ($urandom_range(0, 3) == 0) begin
                hue = hue_corners[$urandom_range(0, 4)];
            end else begin
                hue = t_hue'($urandom_range(0, 511));
            end
            set_hue(hue);
            repeat (25) begin
                kind = $urandom_range(0, 7);
                r = t_pix'($urandom_range(0, 255));
                g = t_pix'($urandom_range(0, 255));
                b = t_pix'($urandom_range(0, 255));
                case (kind)
                    0: begin
                        // gray
                        g = r;
                        b = r;
                    end
                    1: begin
                        // channels at the rails only
                        r = {8{r[0]}};
                        g = {8{g[0]}};
                        b = {8{b[0]}};
                    end
                    2: begin
                        // two channels tie
                        g = r;
                    end
                    3: begin
                        // red and green one code apart, stresses truncation
                        g = r ^ 8'd1;
                    end
                    default: begin
                    end
                endcase
                send_pixel(r, g, b);
            end
        end
        calm = 1'b0;

        // drain: every result back, then a few quiet cycles for strays
        in_valid = 1'b0;
        while (pending != 0) @(negedge clk);
        repeat (8) @(negedge clk);

        $display("Sent %0d pixels under %0d hue writes: gray, rail, tied and random pixels,",
                 pixels_sent, hue_writes);
        $display("hues on ramp boundaries and wrapped values, with random gaps and stalls.");
        if (fail_count == 0) begin
            $display("CHECK OK");
        end else begin
            $display("CHECK FAILED");
        end
        $finish;
    end

    // watchdog, far beyond the slowest legal run
    initial begin : watchdog
        #2000000;
        $display("CHECK FAILED");
        $finish;
    end

endmodule
